FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sphere pair collision time unit.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SPCT_ASSERT(label, ck, rn, prop) \
	label: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("spct assertion failed");
`define SPCT_ASSERT_ALWAYS(label, ck, prop) \
	label: assert property (@(posedge ck) prop) \
		else $error("spct assertion failed");
`else
`define SPCT_ASSERT(label, ck, rn, prop)
`define SPCT_ASSERT_ALWAYS(label, ck, prop)
`endif
`endif

FILE: rtl/spct_pkg.sv
// Constants, status codes and sideband types of the sphere pair collision time unit.
// No dependencies; used by every module of the unit.
`default_nettype none
package spct_pkg;

	localparam int FRAC_BITS      = 24;
	localparam int NO_HIT_SECONDS = 1000000;
	localparam int TIME_W         = 48;
	localparam int QB             = TIME_W - 1;
	localparam int VS_W           = 64;
	localparam int DISC_W         = 130;
	localparam int ROOT_W         = DISC_W / 2;
	localparam int REM_W          = ROOT_W + 2;
	localparam int XNH_W          = 84;
	localparam int NMAG_W         = XNH_W + 1;
	localparam int NUM_W          = NMAG_W + FRAC_BITS;
	localparam int STAT_W         = 2;

	localparam logic [STAT_W-1:0] ST_ROOT       = 2'd0;
	localparam logic [STAT_W-1:0] ST_ZERO_SPEED = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_ROOT    = 2'd2;

	localparam logic [19:0] NO_HIT_K = 20'(NO_HIT_SECONDS);

	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic [63:0] ZS_RAW = 64'(NO_HIT_SECONDS) << FRAC_BITS;
	localparam logic [TIME_W-1:0] ZERO_SPEED_TIME =
		(ZS_RAW > 64'(TIME_MAX)) ? TIME_MAX : ZS_RAW[TIME_W-1:0];

	typedef struct packed {
		logic [VS_W-1:0]  vs;
		logic [63:0]      dmag;
		logic             dneg;
		logic             hit;
		logic             vs_zero;
		logic [XNH_W-1:0] xnh;
	} spct_side_t;

endpackage
`default_nettype wire

FILE: rtl/sphere_pair_collision_time_unit.sv
// Top level of the sphere pair collision time unit: port unpacking and output skid buffer.
// Depends on spct_pkg, spct_front, spct_isqrt, spct_div and assert_macros.svh.
//
// channel   dir  beat payload
// s_*       in   rel_pos_x/y/z, rel_vel_x/y/z (signed Q8.24), first/second_radius (Q1.24)
// m_*       out  impact_time (signed Q24.24, saturating), hit_status in tuser
//
// One beat in, one beat out. A pair can enter every cycle while s_tready is high; a beat
// passes 6 front stages (products, sums, partial products, the
// discriminant), 65 square root stages (one root bit each), 2 numerator/range
// stages and 47 divide stages (one quotient bit each), then the output register.
// arst_n clears only the valid bits; payload registers carry no reset.
// A stalled output beat parks in a one-entry skid; s_tready drops only once that
// skid is full, and the whole pipeline then holds until the output drains.
`default_nettype none
`include "assert_macros.svh"
module sphere_pair_collision_time_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
	// first_radius, second_radius, then 6 zero bits
	input  logic [247:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// impact_time
	output logic [47:0]  m_tdata,
	// hit_status
	output logic [1:0]   m_tuser
);
	import spct_pkg::*;

	logic en;
	logic f_valid, r_valid, d_valid;
	logic [DISC_W-1:0] f_disc;
	spct_side_t f_side, r_side;
	logic [ROOT_W-1:0] r_root;
	logic [TIME_W-1:0] d_time;
	logic [STAT_W-1:0] d_status;

	logic out_valid_q, skid_valid_q;
	logic [TIME_W-1:0] out_time_q, skid_time_q;
	logic [STAT_W-1:0] out_status_q, skid_status_q;
	logic push, pop;
	logic out_stall, zs_beat;

	// advance the whole pipeline while the skid has room
	assign en       = !skid_valid_q;
	assign s_tready = en;
	assign push     = en && d_valid;
	assign pop      = out_valid_q && m_tready;

	spct_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_tvalid),
		.rel_pos_x    (s_tdata[31:0]),
		.rel_pos_y    (s_tdata[63:32]),
		.rel_pos_z    (s_tdata[95:64]),
		.rel_vel_x    (s_tdata[127:96]),
		.rel_vel_y    (s_tdata[159:128]),
		.rel_vel_z    (s_tdata[191:160]),
		.first_radius (s_tdata[216:192]),
		.second_radius(s_tdata[241:217]),
		.out_valid    (f_valid),
		.disc         (f_disc),
		.side         (f_side)
	);

	spct_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.disc     (f_disc),
		.side_in  (f_side),
		.out_valid(r_valid),
		.root     (r_root),
		.side_out (r_side)
	);

	spct_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (r_valid),
		.root       (r_root),
		.side_in    (r_side),
		.out_valid  (d_valid),
		.impact_time(d_time),
		.hit_status (d_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// drain the skid into the output register
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_time_q   <= skid_time_q;
				out_status_q <= skid_status_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_time_q   <= d_time;
				out_status_q <= d_status;
			end else begin
				skid_time_q   <= d_time;
				skid_status_q <= d_status;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_time_q;
	assign m_tuser  = out_status_q;

	assign out_stall = m_tvalid && !m_tready;
	assign zs_beat   = m_tvalid && (m_tuser == ST_ZERO_SPEED);

	`SPCT_ASSERT(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`SPCT_ASSERT(a_skid_fills_on_stall, clk, arst_n, $rose(skid_valid_q) |-> $past(out_stall))
	`SPCT_ASSERT(a_zero_speed_time, clk, arst_n, zs_beat |-> (m_tdata == ZERO_SPEED_TIME))
	`SPCT_ASSERT_ALWAYS(a_no_valid_in_reset, clk, !arst_n |-> !m_tvalid)

endmodule
`default_nettype wire

FILE: rtl/spct_front.sv
// Front end: dot products, contact term, discriminant (six register stages).
// Depends on spct_pkg.
`default_nettype none
module spct_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [31:0]        rel_pos_x,
	input  logic signed [31:0]        rel_pos_y,
	input  logic signed [31:0]        rel_pos_z,
	input  logic signed [31:0]        rel_vel_x,
	input  logic signed [31:0]        rel_vel_y,
	input  logic signed [31:0]        rel_vel_z,
	input  logic [24:0]               first_radius,
	input  logic [24:0]               second_radius,
	output logic                      out_valid,
	output logic [spct_pkg::DISC_W-1:0] disc,
	output spct_pkg::spct_side_t      side
);
	import spct_pkg::*;

	logic signed [31:0] pos [3];
	logic signed [31:0] vel [3];
	logic [25:0] rsum;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [63:0] vv_s1 [3];
	logic signed [63:0] rr_s1 [3];
	logic signed [63:0] vr_s1 [3];
	logic [51:0] ds_s1;

	logic [63:0] vs_s2, rs_s2;
	logic signed [65:0] dot_s2;
	logic [51:0] ds_s2;

	logic signed [65:0] dot_neg;
	logic [63:0] vs_s3, dmag_s3, cmag_s3;
	logic dneg_s3, cneg_s3, vz_s3;

	logic [63:0] dd00_s4, dd01_s4, dd11_s4;
	logic [63:0] vc00_s4, vc01_s4, vc10_s4, vc11_s4;
	logic [51:0] vm0_s4, vm1_s4;
	logic [63:0] vs_s4, dmag_s4;
	logic dneg_s4, cneg_s4, vz_s4;

	logic [127:0] dot2_s5, x_s5;
	logic [XNH_W-1:0] xnh_s5;
	logic [63:0] vs_s5, dmag_s5;
	logic dneg_s5, cneg_s5, vz_s5;

	logic [128:0] sum_w, diff_w;
	logic gt_w;
	logic [DISC_W-1:0] disc_s6;
	spct_side_t side_s6;

	assign pos[0] = rel_pos_x;
	assign pos[1] = rel_pos_y;
	assign pos[2] = rel_pos_z;
	assign vel[0] = rel_vel_x;
	assign vel[1] = rel_vel_y;
	assign vel[2] = rel_vel_z;
	assign rsum   = 26'(first_radius) + 26'(second_radius);
	assign dot_neg = -dot_s2;

	assign sum_w  = {1'b0, dot2_s5} + {1'b0, x_s5};
	assign diff_w = {1'b0, dot2_s5} - {1'b0, x_s5};
	assign gt_w   = !diff_w[128] && (diff_w[127:0] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// squares and cross products
			for (int k = 0; k < 3; k++) begin
				vv_s1[k] <= vel[k] * vel[k];
				rr_s1[k] <= pos[k] * pos[k];
				vr_s1[k] <= vel[k] * pos[k];
			end
			ds_s1 <= 52'(rsum) * 52'(rsum);

			vs_s2  <= 64'(vv_s1[0]) + 64'(vv_s1[1]) + 64'(vv_s1[2]);
			rs_s2  <= 64'(rr_s1[0]) + 64'(rr_s1[1]) + 64'(rr_s1[2]);
			dot_s2 <= 66'(vr_s1[0]) + 66'(vr_s1[1]) + 66'(vr_s1[2]);
			ds_s2  <= ds_s1;

			vs_s3   <= vs_s2;
			vz_s3   <= (vs_s2 == '0);
			dneg_s3 <= dot_s2[65];
			dmag_s3 <= dot_s2[65] ? dot_neg[63:0] : dot_s2[63:0];
			cneg_s3 <= 64'(ds_s2) > rs_s2;
			cmag_s3 <= (64'(ds_s2) > rs_s2) ? 64'(ds_s2) - rs_s2 : rs_s2 - 64'(ds_s2);

			// 32-bit partial products of the wide squares
			dd00_s4 <= 64'(dmag_s3[31:0]) * 64'(dmag_s3[31:0]);
			dd01_s4 <= 64'(dmag_s3[31:0]) * 64'(dmag_s3[63:32]);
			dd11_s4 <= 64'(dmag_s3[63:32]) * 64'(dmag_s3[63:32]);
			vc00_s4 <= 64'(vs_s3[31:0]) * 64'(cmag_s3[31:0]);
			vc01_s4 <= 64'(vs_s3[31:0]) * 64'(cmag_s3[63:32]);
			vc10_s4 <= 64'(vs_s3[63:32]) * 64'(cmag_s3[31:0]);
			vc11_s4 <= 64'(vs_s3[63:32]) * 64'(cmag_s3[63:32]);
			vm0_s4  <= 52'(vs_s3[31:0]) * 52'(NO_HIT_K);
			vm1_s4  <= 52'(vs_s3[63:32]) * 52'(NO_HIT_K);
			vs_s4   <= vs_s3;
			dmag_s4 <= dmag_s3;
			dneg_s4 <= dneg_s3;
			cneg_s4 <= cneg_s3;
			vz_s4   <= vz_s3;

			dot2_s5 <= {dd11_s4, 64'b0} + {31'b0, dd01_s4, 33'b0} + 128'(dd00_s4);
			x_s5    <= {vc11_s4, 64'b0} + {32'b0, vc01_s4, 32'b0}
				+ {32'b0, vc10_s4, 32'b0} + 128'(vc00_s4);
			xnh_s5  <= {vm1_s4, 32'b0} + XNH_W'(vm0_s4);
			vs_s5   <= vs_s4;
			dmag_s5 <= dmag_s4;
			dneg_s5 <= dneg_s4;
			cneg_s5 <= cneg_s4;
			vz_s5   <= vz_s4;

			// real root when the contact term is negative or dot^2 beats vs*c
			disc_s6         <= cneg_s5 ? DISC_W'(sum_w) : DISC_W'(diff_w[127:0]);
			side_s6.vs      <= vs_s5;
			side_s6.dmag    <= dmag_s5;
			side_s6.dneg    <= dneg_s5;
			side_s6.hit     <= cneg_s5 | gt_w;
			side_s6.vs_zero <= vz_s5;
			side_s6.xnh     <= xnh_s5;
		end
	end

	assign out_valid = v_s6;
	assign disc      = disc_s6;
	assign side      = side_s6;

endmodule
`default_nettype wire

FILE: rtl/spct_isqrt.sv
// Pipelined floor square root of the discriminant, one root bit per stage.
// Depends on spct_pkg.
`default_nettype none
module spct_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [spct_pkg::DISC_W-1:0] disc,
	input  spct_pkg::spct_side_t        side_in,
	output logic                        out_valid,
	output logic [spct_pkg::ROOT_W-1:0] root,
	output spct_pkg::spct_side_t        side_out
);
	import spct_pkg::*;

	logic              v_s    [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [DISC_W-1:0] disc_s [ROOT_W];
	spct_side_t        side_s [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic              v_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [DISC_W-1:0] disc_in;
		spct_side_t        side_i;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign disc_in = disc;
			assign side_i  = side_in;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign disc_in = disc_s[i-1];
			assign side_i  = side_s[i-1];
		end

		// bring down the next bit pair, try root*4+1
		assign rem_sh = {rem_in[REM_W-3:0], disc_in[DISC_W-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? rem_sh - trial : rem_sh;
				root_s[i] <= {root_in[ROOT_W-2:0], ge};
				disc_s[i] <= {disc_in[DISC_W-3:0], 2'b00};
				side_s[i] <= side_i;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign side_out  = side_s[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/spct_div.sv
// Numerator, saturation check and pipelined restoring divide by vs, then time format.
// Depends on spct_pkg.
`default_nettype none
module spct_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [spct_pkg::ROOT_W-1:0] root,
	input  spct_pkg::spct_side_t        side_in,
	output logic                        out_valid,
	output logic [spct_pkg::TIME_W-1:0] impact_time,
	output logic [spct_pkg::STAT_W-1:0] hit_status
);
	import spct_pkg::*;

	logic [XNH_W-1:0]  x_w;
	logic [NUM_W-1:0]  num_w;
	logic [NUM_W-QB-1:0] rem0_w;

	logic              v_s1, v_s2;
	logic [NMAG_W-1:0] nmag_s1;
	logic              nneg_s1, vz_s1;
	logic [VS_W-1:0]   vs_s1;
	logic [STAT_W-1:0] st_s1;

	logic              sat_s2, nneg_s2, vz_s2;
	logic [VS_W-1:0]   vs_s2, rem_s2;
	logic [QB-1:0]     nlo_s2;
	logic [STAT_W-1:0] st_s2;

	logic              v_q    [QB];
	logic [VS_W-1:0]   rem_q  [QB];
	logic [QB-1:0]     quo_q  [QB];
	logic [QB-1:0]     nlo_q  [QB];
	logic [VS_W-1:0]   vs_q   [QB];
	logic              sat_q  [QB];
	logic              nneg_q [QB];
	logic              vz_q   [QB];
	logic [STAT_W-1:0] st_q   [QB];

	logic [TIME_W-1:0] mag_w;
	logic [TIME_W-1:0] neg_w;

	assign x_w    = side_in.hit ? XNH_W'(root) : side_in.xnh;
	assign num_w  = {nmag_s1, {FRAC_BITS{1'b0}}};
	assign rem0_w = num_w[NUM_W-1:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// numerator = -(dot + x) as sign and magnitude
			if (!side_in.dneg) begin
				nneg_s1 <= 1'b1;
				nmag_s1 <= NMAG_W'(side_in.dmag) + NMAG_W'(x_w);
			end else if (XNH_W'(side_in.dmag) >= x_w) begin
				nneg_s1 <= 1'b0;
				nmag_s1 <= NMAG_W'(side_in.dmag) - NMAG_W'(x_w);
			end else begin
				nneg_s1 <= 1'b1;
				nmag_s1 <= NMAG_W'(x_w) - NMAG_W'(side_in.dmag);
			end
			vs_s1 <= side_in.vs;
			vz_s1 <= side_in.vs_zero;
			if (side_in.vs_zero) begin
				st_s1 <= ST_ZERO_SPEED;
			end else if (side_in.hit) begin
				st_s1 <= ST_ROOT;
			end else begin
				st_s1 <= ST_NO_ROOT;
			end

			// quotient at or above 2^47 saturates either way
			sat_s2  <= VS_W'(rem0_w) >= vs_s1;
			rem_s2  <= VS_W'(rem0_w);
			nlo_s2  <= num_w[QB-1:0];
			vs_s2   <= vs_s1;
			nneg_s2 <= nneg_s1;
			vz_s2   <= vz_s1;
			st_s2   <= st_s1;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic              v_in;
		logic [VS_W-1:0]   rem_in;
		logic [QB-1:0]     quo_in;
		logic [QB-1:0]     nlo_in;
		logic [VS_W-1:0]   vs_in;
		logic              sat_in, nneg_in, vz_in;
		logic [STAT_W-1:0] st_in;
		logic [VS_W:0]     rem_sh;
		logic              ge;

		if (j == 0) begin : g_first
			assign v_in    = v_s2;
			assign rem_in  = rem_s2;
			assign quo_in  = '0;
			assign nlo_in  = nlo_s2;
			assign vs_in   = vs_s2;
			assign sat_in  = sat_s2;
			assign nneg_in = nneg_s2;
			assign vz_in   = vz_s2;
			assign st_in   = st_s2;
		end else begin : g_next
			assign v_in    = v_q[j-1];
			assign rem_in  = rem_q[j-1];
			assign quo_in  = quo_q[j-1];
			assign nlo_in  = nlo_q[j-1];
			assign vs_in   = vs_q[j-1];
			assign sat_in  = sat_q[j-1];
			assign nneg_in = nneg_q[j-1];
			assign vz_in   = vz_q[j-1];
			assign st_in   = st_q[j-1];
		end

		assign rem_sh = {rem_in, nlo_in[QB-1]};
		assign ge     = rem_sh >= {1'b0, vs_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (en) begin
				v_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= ge ? VS_W'(rem_sh - {1'b0, vs_in}) : VS_W'(rem_sh);
				quo_q[j]  <= {quo_in[QB-2:0], ge};
				nlo_q[j]  <= {nlo_in[QB-2:0], 1'b0};
				vs_q[j]   <= vs_in;
				sat_q[j]  <= sat_in;
				nneg_q[j] <= nneg_in;
				vz_q[j]   <= vz_in;
				st_q[j]   <= st_in;
			end
		end
	end

	assign mag_w = {1'b0, quo_q[QB-1]};
	assign neg_w = -mag_w;

	always_comb begin
		if (vz_q[QB-1]) begin
			impact_time = ZERO_SPEED_TIME;
		end else if (sat_q[QB-1]) begin
			impact_time = nneg_q[QB-1] ? TIME_MIN : TIME_MAX;
		end else begin
			impact_time = nneg_q[QB-1] ? neg_w : mag_w;
		end
	end

	assign hit_status = st_q[QB-1];
	assign out_valid  = v_q[QB-1];

endmodule
`default_nettype wire
